// ===== design/firxf_pkg.sv =====
// Shared types and constants for the FIR filter with tap crossfade.
// No dependencies; every other file of the block imports this package.
package firxf_pkg;

    localparam int DEF_MAX_TAPS    = 64;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_TAP_BITS    = 18;

    // Taps are Q4.x: four integer bits, the rest fraction.
    localparam int TAP_INT_BITS = 4;
    localparam int FADE_BITS    = 16;
    // Weight is Q0.16 with one extra bit so that 65536 means exactly 1.0.
    localparam int WEIGHT_FRAC  = 16;
    localparam int WEIGHT_BITS  = WEIGHT_FRAC + 1;
    // Dividend of the weight division: (step + 1) * 2^16 + den / 2.
    localparam int DIV_NUM_BITS = FADE_BITS + 1 + WEIGHT_FRAC + 1;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_STAGE  = 2'd1,
        ACT_COMMIT = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef struct packed {
        logic rotate;
        logic shift;
        logic clear;
        logic stage_we;
        logic copy_all;
        logic start_fade;
    } t_cell_ctrl;

endpackage

// ===== design/firxf_cell.sv =====
// One tap cell: a delay-line sample and the active, target, prior and staged taps.
// Depends on firxf_pkg for the control struct and the tap format.
module firxf_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int TAP_BITS    = 18,
    parameter int IDX_W       = 6,
    parameter int CELL_IDX    = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  firxf_pkg::t_cell_ctrl         i_ctrl,
    input  logic        [IDX_W-1:0]       i_stage_idx,
    input  logic signed [TAP_BITS-1:0]    i_stage_val,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_d,
    input  logic signed [SAMPLE_BITS-1:0] i_nb_d,
    input  logic signed [TAP_BITS-1:0]    i_nb_a,
    input  logic signed [TAP_BITS-1:0]    i_nb_t,
    input  logic signed [TAP_BITS-1:0]    i_nb_p,
    input  logic signed [TAP_BITS-1:0]    i_nb_s,
    output logic signed [SAMPLE_BITS-1:0] o_d,
    output logic signed [TAP_BITS-1:0]    o_a,
    output logic signed [TAP_BITS-1:0]    o_t,
    output logic signed [TAP_BITS-1:0]    o_p,
    output logic signed [TAP_BITS-1:0]    o_s
);
    import firxf_pkg::*;

    // Tap zero starts at 1.0, every other tap at zero.
    localparam logic signed [TAP_BITS-1:0] RST_TAP =
        (CELL_IDX == 0) ? TAP_BITS'(1 << (TAP_BITS - TAP_INT_BITS)) : '0;

    logic signed [SAMPLE_BITS-1:0] r_d;
    logic signed [TAP_BITS-1:0]    r_a;
    logic signed [TAP_BITS-1:0]    r_t;
    logic signed [TAP_BITS-1:0]    r_p;
    logic signed [TAP_BITS-1:0]    r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
            r_a <= RST_TAP;
            r_t <= RST_TAP;
            r_p <= RST_TAP;
            r_s <= RST_TAP;
        end else begin
            if (i_ctrl.clear) begin
                r_d <= '0;
            end else if (i_ctrl.shift) begin
                r_d <= i_prev_d;
            end else if (i_ctrl.rotate) begin
                r_d <= i_nb_d;
            end

            if (i_ctrl.copy_all) begin
                r_a <= r_s;
                r_t <= r_s;
                r_p <= r_s;
            end else if (i_ctrl.start_fade) begin
                r_p <= r_a;
                r_t <= r_s;
            end else if (i_ctrl.rotate) begin
                r_a <= i_nb_a;
                r_t <= i_nb_t;
                r_p <= i_nb_p;
                r_s <= i_nb_s;
            end

            if (i_ctrl.stage_we && (i_stage_idx == IDX_W'(CELL_IDX))) begin
                r_s <= i_stage_val;
            end
        end
    end

    assign o_d = r_d;
    assign o_a = r_a;
    assign o_t = r_t;
    assign o_p = r_p;
    assign o_s = r_s;

endmodule

// ===== design/firxf_div.sv =====
// Restoring divider for the crossfade weight, one quotient bit per cycle.
// Depends on firxf_pkg for the fade and weight widths.
module firxf_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [firxf_pkg::FADE_BITS-1:0]        i_step,
    input  logic [firxf_pkg::FADE_BITS-1:0]        i_total,
    output logic                                   o_done,
    output logic [firxf_pkg::WEIGHT_BITS-1:0]      o_weight
);
    import firxf_pkg::*;

    localparam int DEN_W = FADE_BITS + 1;
    localparam int CNT_W = $clog2(DIV_NUM_BITS);

    logic [DIV_NUM_BITS-1:0] r_num;
    logic [DEN_W-1:0]        r_den;
    logic [DEN_W-1:0]        r_rem;
    logic [WEIGHT_BITS-1:0]  r_quo;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_done;

    logic [DEN_W-1:0]        n_den;
    logic [DEN_W:0]          n_rem2;
    logic                    n_ge;

    assign n_den  = DEN_W'(i_total) + DEN_W'(1);
    assign n_rem2 = {r_rem, r_num[DIV_NUM_BITS-1]};
    assign n_ge   = n_rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= n_den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_num  <= (DIV_NUM_BITS'(DEN_W'(i_step) + DEN_W'(1)) << WEIGHT_FRAC)
                          + DIV_NUM_BITS'(n_den >> 1);
            end else if (r_busy) begin
                r_num <= r_num << 1;
                r_rem <= n_ge ? DEN_W'(n_rem2 - {1'b0, r_den}) : DEN_W'(n_rem2);
                r_quo <= {r_quo[WEIGHT_BITS-2:0], n_ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_NUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_weight = r_quo;

endmodule

// ===== design/fir_filter_coef_crossfade_top.sv =====
// Top level of the FIR filter with linear tap crossfade: sequencer, shared
// blend and multiply-accumulate datapath, a ring of tap cells and the weight divider.
// Depends on firxf_pkg, firxf_cell and firxf_div.
//
//  Channel  | Signals                              | Direction
//  ---------+--------------------------------------+----------
//  cfg      | i_cfg_we, i_cfg_wdata                | in
//  in       | i_in_valid/o_in_ready + action field | in
//  out      | o_out_valid/i_out_ready, o_sample_out| out
//
// A sample makes a multiply-accumulate pass of the cell ring, preceded while a fade
// runs by the 34-step weight divider and a second pass of the ring for the tap
// blend. A commit makes a compare pass, but copies the staged taps without one right
// after a tap count write; tap writes and clears do not leave the idle state.
// Reset is synchronous and active low.
// A finished sample waits in the output register; only a further sample that
// finishes while it still waits stalls the block.
module fir_filter_coef_crossfade_top #(
    parameter int MAX_TAPS    = firxf_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = firxf_pkg::DEF_SAMPLE_BITS,
    parameter int TAP_BITS    = firxf_pkg::DEF_TAP_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [$clog2(MAX_TAPS+1)-1:0]          i_cfg_wdata,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_action,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample_in,
    input  logic [((MAX_TAPS>1)?$clog2(MAX_TAPS):1)-1:0] i_tap_index,
    input  logic signed [TAP_BITS-1:0]             i_tap_value,
    input  logic [firxf_pkg::FADE_BITS-1:0]        i_fade_length,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]          o_sample_out
);
    import firxf_pkg::*;

    localparam int IDX_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W    = SAMPLE_BITS + TAP_BITS + CNT_W;
    localparam int TAP_FRAC = TAP_BITS - TAP_INT_BITS;
    localparam int DIFF_W   = TAP_BITS + 1;
    localparam int BL_W     = DIFF_W + WEIGHT_BITS + 2;

    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) <<< (TAP_FRAC - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI  = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO  = -SAT_HI - ACC_W'(1);
    localparam logic signed [BL_W-1:0]  BL_RND  = BL_W'(1) <<< (WEIGHT_FRAC - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_BLEND, S_SHIFT, S_MAC, S_CMP, S_CMT, S_OUT
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         r_tap_count;
    logic                     r_fading;
    logic                     r_size_changed;
    logic [FADE_BITS-1:0]     r_fade_step;
    logic [FADE_BITS-1:0]     r_fade_total;
    logic [FADE_BITS-1:0]     r_len;
    logic                     r_mismatch;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;

    logic signed [SAMPLE_BITS-1:0] w_d [MAX_TAPS];
    logic signed [TAP_BITS-1:0]    w_a [MAX_TAPS];
    logic signed [TAP_BITS-1:0]    w_t [MAX_TAPS];
    logic signed [TAP_BITS-1:0]    w_p [MAX_TAPS];
    logic signed [TAP_BITS-1:0]    w_s [MAX_TAPS];

    t_cell_ctrl               c_ctrl;
    t_action                  c_act;
    logic                     c_accept;
    logic                     c_last;
    logic                     c_in_use;
    logic [CNT_W-1:0]         c_tap_count;
    logic                     c_div_done;
    logic [WEIGHT_BITS-1:0]   c_weight;
    logic signed [DIFF_W-1:0] c_diff;
    logic signed [BL_W-1:0]   c_blend_sum;
    logic signed [TAP_BITS-1:0] c_blend;
    logic signed [TAP_BITS-1:0] c_wrap_a;
    logic signed [TAP_BITS+SAMPLE_BITS-1:0] c_prod;
    logic signed [ACC_W-1:0]  c_y;
    logic signed [SAMPLE_BITS-1:0] c_y_sat;
    logic                     c_out_free;

    assign c_act      = t_action'(i_action);
    assign o_in_ready = (r_state == S_IDLE);
    assign c_accept   = i_in_valid && o_in_ready;
    assign c_last     = (r_cnt == CNT_W'(MAX_TAPS - 1));
    assign c_in_use   = (r_cnt < r_tap_count);
    assign c_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            c_tap_count = CNT_W'(1);
        end else if (i_cfg_wdata > CNT_W'(MAX_TAPS)) begin
            c_tap_count = CNT_W'(MAX_TAPS);
        end else begin
            c_tap_count = i_cfg_wdata;
        end
    end

    always_comb begin
        c_ctrl.rotate     = (r_state == S_BLEND) || (r_state == S_MAC) || (r_state == S_CMP);
        c_ctrl.shift      = (r_state == S_SHIFT);
        c_ctrl.clear      = i_cfg_we || (c_accept && (c_act == ACT_CLEAR));
        c_ctrl.stage_we   = c_accept && (c_act == ACT_STAGE);
        c_ctrl.copy_all   = c_accept && (c_act == ACT_COMMIT) && r_size_changed;
        c_ctrl.start_fade = (r_state == S_CMT) && r_mismatch;
    end

    // Blend at the head of the ring: prior + (target - prior) * w, rounded to nearest.
    assign c_diff      = DIFF_W'(w_t[0]) - DIFF_W'(w_p[0]);
    assign c_blend_sum = (BL_W'(w_p[0]) <<< WEIGHT_FRAC)
                         + BL_W'(c_diff * $signed({1'b0, c_weight})) + BL_RND;
    assign c_blend     = c_blend_sum[WEIGHT_FRAC +: TAP_BITS];
    assign c_wrap_a    = (r_state == S_BLEND) ? c_blend : w_a[0];

    assign c_prod = w_a[0] * w_d[0];

    assign c_y = (r_acc + ACC_RND) >>> TAP_FRAC;
    always_comb begin
        if (c_y > SAT_HI) begin
            c_y_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (c_y < SAT_LO) begin
            c_y_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            c_y_sat = c_y[SAMPLE_BITS-1:0];
        end
    end

    firxf_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (c_accept && (c_act == ACT_SAMPLE) && r_fading),
        .i_step   (r_fade_step),
        .i_total  (r_fade_total),
        .o_done   (c_div_done),
        .o_weight (c_weight)
    );

    // Ring of cells: during a pass each cell takes its upper neighbor's contents,
    // so the head cell sees every entry once and all return home at the end.
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        localparam int UP = (k == MAX_TAPS - 1) ? 0 : k + 1;
        logic signed [SAMPLE_BITS-1:0] c_prev_d;
        logic signed [TAP_BITS-1:0]    c_nb_a;

        if (k == 0) begin : g_head
            assign c_prev_d = r_x;
        end else begin : g_body
            assign c_prev_d = w_d[k-1];
        end

        if (k == MAX_TAPS - 1) begin : g_tail
            assign c_nb_a = c_wrap_a;
        end else begin : g_mid
            assign c_nb_a = w_a[UP];
        end

        firxf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .TAP_BITS    (TAP_BITS),
            .IDX_W       (IDX_W),
            .CELL_IDX    (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (c_ctrl),
            .i_stage_idx (i_tap_index),
            .i_stage_val (i_tap_value),
            .i_prev_d    (c_prev_d),
            .i_nb_d      (w_d[UP]),
            .i_nb_a      (c_nb_a),
            .i_nb_t      (w_t[UP]),
            .i_nb_p      (w_p[UP]),
            .i_nb_s      (w_s[UP]),
            .o_d         (w_d[k]),
            .o_a         (w_a[k]),
            .o_t         (w_t[k]),
            .o_p         (w_p[k]),
            .o_s         (w_s[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_tap_count    <= CNT_W'(1);
            r_fading       <= 1'b0;
            r_size_changed <= 1'b0;
            r_fade_step    <= '0;
            r_fade_total   <= '0;
            r_mismatch     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_tap_count    <= c_tap_count;
                r_fading       <= 1'b0;
                r_fade_step    <= '0;
                r_fade_total   <= '0;
                r_size_changed <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (c_accept) begin
                        case (c_act)
                            ACT_SAMPLE: begin
                                r_x     <= i_sample_in;
                                r_state <= r_fading ? S_DIV : S_SHIFT;
                            end
                            ACT_COMMIT: begin
                                if (r_size_changed) begin
                                    r_fading       <= 1'b0;
                                    r_fade_step    <= '0;
                                    r_fade_total   <= '0;
                                    r_size_changed <= 1'b0;
                                end else begin
                                    r_len      <= i_fade_length;
                                    r_mismatch <= 1'b0;
                                    r_state    <= S_CMP;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (c_div_done) begin
                        r_state <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (c_last) begin
                        r_cnt <= '0;
                        if (r_fade_step >= r_fade_total) begin
                            r_fading <= 1'b0;
                        end else begin
                            r_fade_step <= r_fade_step + FADE_BITS'(1);
                        end
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (c_in_use) begin
                        r_acc <= r_acc + ACC_W'(c_prod);
                    end
                    if (c_last) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (c_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_sample_out <= c_y_sat;
                        r_state      <= S_IDLE;
                    end
                end
                S_CMP: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (c_in_use && (w_s[0] != w_t[0])) begin
                        r_mismatch <= 1'b1;
                    end
                    if (c_last) begin
                        r_state <= S_CMT;
                    end
                end
                S_CMT: begin
                    if (r_mismatch) begin
                        r_fade_total <= r_len;
                        r_fade_step  <= '0;
                        r_fading     <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

endmodule

// ===== design/firxf_chk.sv =====
// Port-level checks for the FIR crossfade filter, bound to the top level.
// Depends on firxf_pkg for the action codes.
module firxf_chk #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic [1:0]             i_action,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] o_sample_out
);
    import firxf_pkg::*;

    logic c_in_xfer;
    assign c_in_xfer = i_in_valid && o_in_ready;

    // A waiting result is neither dropped nor changed before its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("output result changed or dropped while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // A sample transfer makes the block busy, as its filter pass starts.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_in_xfer && (i_action == ACT_SAMPLE) |=> !o_in_ready)
        else $error("sample transfer did not start a filter pass");

    a_quick_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_in_xfer && (i_action == ACT_STAGE || i_action == ACT_CLEAR) |=> o_in_ready)
        else $error("tap write or clear did not finish in one cycle");

endmodule

bind fir_filter_coef_crossfade_top firxf_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_firxf_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_action     (i_action),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out)
);

// ===== verif/fir_filter_coef_crossfade_top_tb.sv =====
// Self-checking testbench for fir_filter_coef_crossfade_top: directed table, then random
// bursts of tap writes, commits, clears and samples, checked with a behavioral predictor.
// Depends on firxf_pkg and the design files of the block.
`timescale 1ns / 1ps

module fir_filter_coef_crossfade_top_tb;
    import firxf_pkg::*;

    localparam int NTAPS = 64;
    localparam int SETTLE = 300;

    typedef struct {
        t_action          act;
        logic signed [15:0] smp;
        logic [5:0]       idx;
        logic signed [17:0] tval;
        logic [15:0]      flen;
        bit               known;
        logic signed [15:0] want;
    } t_row;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [6:0]         i_cfg_wdata = '0;
    logic               i_in_valid = 0;
    logic               o_in_ready;
    logic [1:0]         i_action = '0;
    logic signed [15:0] i_sample_in = '0;
    logic [5:0]         i_tap_index = '0;
    logic signed [17:0] i_tap_value = '0;
    logic [15:0]        i_fade_length = '0;
    logic               o_out_valid;
    logic               i_out_ready = 0;
    logic signed [15:0] o_sample_out;

    fir_filter_coef_crossfade_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_action(i_action),
        .i_sample_in(i_sample_in), .i_tap_index(i_tap_index), .i_tap_value(i_tap_value),
        .i_fade_length(i_fade_length), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_sample_out(o_sample_out)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // Predictor state.
    int          n_taps;
    longint      line_mem[NTAPS];
    int          head;
    longint      act_c[NTAPS], tgt_c[NTAPS], old_c[NTAPS], stg_c[NTAPS];
    int          f_step, f_total;
    bit          blending, resized;

    logic signed [15:0] expected_q[$];
    int  errors = 0;
    bit  hold_long = 0;
    int  stim_done = 0;

    function automatic longint fdiv(longint v, int sh);
        return (v - ((v % (64'sd1 <<< sh) + (64'sd1 <<< sh)) % (64'sd1 <<< sh))) / (64'sd1 <<< sh);
    endfunction

    task automatic model_reset();
        n_taps = 1; head = 0;
        for (int k = 0; k < NTAPS; k++) begin
            line_mem[k] = 0;
            act_c[k] = (k == 0) ? 16384 : 0;
            tgt_c[k] = act_c[k]; old_c[k] = act_c[k]; stg_c[k] = act_c[k];
        end
        f_step = 0; f_total = 0; blending = 0; resized = 0;
    endtask

    task automatic model_size(int v);
        n_taps = (v == 0) ? 1 : (v > NTAPS ? NTAPS : v);
        for (int k = 0; k < NTAPS; k++) line_mem[k] = 0;
        head = n_taps - 1;
        blending = 0; f_step = 0; f_total = 0; resized = 1;
    endtask

    function automatic logic signed [15:0] filter_out(longint x);
        longint acc, y, w;
        int pos;
        if (blending) begin
            w = ((longint'(f_step) + 1) * 65536 + (f_total + 1) / 2) / (f_total + 1);
            if (w > 65536) w = 65536;
            for (int k = 0; k < NTAPS; k++)
                act_c[k] = fdiv(tgt_c[k] * w + old_c[k] * (65536 - w) + 32768, 16);
            if (f_step >= f_total) blending = 0;
            else f_step++;
        end
        if (head >= n_taps) head = n_taps - 1;
        line_mem[head] = x;
        pos = head; acc = 0;
        for (int k = 0; k < n_taps; k++) begin
            acc += act_c[k] * line_mem[pos];
            pos = (pos + 1 >= n_taps) ? 0 : pos + 1;
        end
        head = (head == 0) ? n_taps - 1 : head - 1;
        y = fdiv(acc + 8192, 14);
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        return y[15:0];
    endfunction

    task automatic model_commit(int len);
        bit same;
        if (resized) begin
            for (int k = 0; k < NTAPS; k++) begin
                act_c[k] = stg_c[k]; tgt_c[k] = stg_c[k]; old_c[k] = stg_c[k];
            end
            blending = 0; f_step = 0; f_total = 0; resized = 0;
        end else begin
            same = 1;
            for (int k = 0; k < n_taps; k++) if (stg_c[k] != tgt_c[k]) same = 0;
            if (!same) begin
                for (int k = 0; k < NTAPS; k++) begin
                    old_c[k] = act_c[k]; tgt_c[k] = stg_c[k];
                end
                f_total = len; f_step = 0; blending = 1;
            end
        end
    endtask

    // Applies one accepted transfer to the predictor.
    task automatic model_item(t_row r);
        logic signed [15:0] y;
        case (r.act)
            ACT_SAMPLE: begin
                y = filter_out(r.smp);
                expected_q.push_back(r.known ? r.want : y);
                if (r.known && y != r.want) begin
                    errors++;
                    if (errors <= 10)
                        $display("table row disagrees with predictor: %0d vs %0d", r.want, y);
                end
            end
            ACT_STAGE: stg_c[r.idx] = r.tval;
            ACT_COMMIT: model_commit(r.flen);
            default: for (int k = 0; k < NTAPS; k++) line_mem[k] = 0;
        endcase
    endtask

    // Offers one item and holds it until the transfer completes.
    task automatic send(t_row r);
        i_in_valid <= 1;
        i_action <= r.act; i_sample_in <= r.smp; i_tap_index <= r.idx;
        i_tap_value <= r.tval; i_fade_length <= r.flen;
        do @(posedge i_clk); while (!o_in_ready);
        model_item(r);
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_size(int v);
        drain();
        i_cfg_we <= 1; i_cfg_wdata <= v[6:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        model_size(v);
    endtask

    function automatic t_row mk(t_action a, int s, int ix, int tv, int fl);
        t_row r;
        r.act = a; r.smp = 16'(s); r.idx = 6'(ix); r.tval = 18'(tv); r.flen = 16'(fl);
        r.known = 0; r.want = 0;
        return r;
    endfunction

    function automatic t_row mk_chk(int s, int w);
        t_row r;
        r = mk(ACT_SAMPLE, s, 0, 0, 0);
        r.known = 1; r.want = 16'(w);
        return r;
    endfunction

    function automatic t_row rnd_row(int p);
        t_row r;
        r = mk(ACT_SAMPLE, $urandom, $urandom, $urandom, $urandom_range(0, 6));
        if (p < 50) r.act = ACT_SAMPLE;
        else if (p < 80) r.act = ACT_STAGE;
        else if (p < 93) r.act = ACT_COMMIT;
        else r.act = ACT_CLEAR;
        if ($urandom_range(0, 7) == 0) r.tval = $urandom_range(0, 1) ? 18'sh1ffff : -18'sh20000;
        if ($urandom_range(0, 40) == 0) r.flen = 16'($urandom);
        if (r.act == ACT_STAGE && $urandom_range(0, 1)) r.idx = 6'($urandom_range(0, 7));
        return r;
    endfunction

    // Output side: random stalls plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_long) i_out_ready <= 0;
        else i_out_ready <= ($urandom_range(0, 3) != 0);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected sample_out %0d", o_sample_out);
            end else begin
                if (o_sample_out !== expected_q[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("sample_out mismatch: expected %0d actual %0d",
                                 expected_q[0], o_sample_out);
                end
                void'(expected_q.pop_front());
            end
        end
    end

    initial begin
        int hold;
        wait (stim_done == 1);
        hold_long = 1;
        hold = 0;
        while (hold < 3000) begin
            @(posedge i_clk);
            hold++;
        end
        hold_long = 0;
    end

    initial begin
        t_row tbl[$];
        int sizes[6] = '{64, 0, 100, 5, 1, 17};
        model_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Tap count 1, tap 0 = 1.0: output equals the input.
        tbl.push_back(mk_chk(32767, 32767));
        tbl.push_back(mk_chk(-32768, -32768));
        tbl.push_back(mk_chk(0, 0));
        tbl.push_back(mk(ACT_COMMIT, 0, 0, 0, 0));              // equal to target, ignored
        tbl.push_back(mk(ACT_STAGE, 0, 0, -131072, 0));
        tbl.push_back(mk(ACT_COMMIT, 0, 0, 0, 0));              // immediate
        tbl.push_back(mk_chk(32767, -32768));                    // -8.0 saturates
        tbl.push_back(mk(ACT_STAGE, 0, 0, 131071, 0));
        tbl.push_back(mk(ACT_STAGE, 0, 63, 12345, 0));
        tbl.push_back(mk(ACT_COMMIT, 0, 0, 0, 3));
        for (int i = 0; i < 4; i++) tbl.push_back(mk(ACT_SAMPLE, -20000 + i * 9000, 0, 0, 0));
        tbl.push_back(mk(ACT_STAGE, 0, 0, 16384, 0));
        tbl.push_back(mk(ACT_COMMIT, 0, 0, 0, 65535));          // long fade
        tbl.push_back(mk(ACT_SAMPLE, 1000, 0, 0, 0));
        tbl.push_back(mk(ACT_STAGE, 0, 0, 8192, 0));
        tbl.push_back(mk(ACT_COMMIT, 0, 0, 0, 1));              // restart during fade
        tbl.push_back(mk(ACT_SAMPLE, 1000, 0, 0, 0));
        tbl.push_back(mk(ACT_CLEAR, 0, 0, 0, 0));
        tbl.push_back(mk(ACT_SAMPLE, 1000, 0, 0, 0));
        foreach (tbl[i]) begin
            send(tbl[i]);
            idle_gap();
        end

        for (int ph = 0; ph < 6; ph++) begin
            write_size(sizes[ph]);
            send(mk(ACT_COMMIT, 0, 0, 0, 0));
            for (int i = 0; i < 65; i++) begin
                if (ph == 2 && i == 10) stim_done = 1;
                send(rnd_row($urandom_range(0, 99)));
                idle_gap();
            end
        end

        drain();
        if (errors == 0)
            $display("fir_filter_coef_crossfade_top_tb passed");
        else
            $display("fir_filter_coef_crossfade_top_tb failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("fir_filter_coef_crossfade_top_tb failed");
        $finish;
    end
endmodule
